FILE: hw/rtl/sgs_pkg.sv
`timescale 1ns / 1ps

package sgs_pkg;

    localparam int KEY_W           = 64;
    localparam int AMT_W           = 32;
    localparam int SUM_W           = 40;
    localparam int MAX_RECORDS_DEF = 64;
    localparam int KEY_BYTES_DEF   = 8;

    typedef struct packed {
        logic [KEY_W-1:0]        product_key;
        logic signed [AMT_W-1:0] amount;
        logic                    final_record;
    } rec_in_t;

    typedef struct packed {
        logic [KEY_W-1:0]        group_key;
        logic signed [SUM_W-1:0] group_total;
        logic                    end_of_groups;
        logic                    records_dropped;
    } rec_out_t;

    // one stored group
    typedef struct packed {
        logic [KEY_W-1:0]        key;
        logic signed [SUM_W-1:0] sum;
    } entry_t;

    // compare status a cell hands to its right neighbour
    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_t;

    // broadcast to every cell
    typedef struct packed {
        logic                    merge;
        logic                    insert;
        logic                    drain;
        logic [KEY_W-1:0]        key;
        logic signed [AMT_W-1:0] amt;
    } ctrl_t;

    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0] a,
        input logic signed [AMT_W-1:0] b
    );
        logic signed [SUM_W:0] s;
        s = {a[SUM_W-1], a} + (SUM_W+1)'(b);
        if (s[SUM_W] != s[SUM_W-1])
        begin
            // clamp towards the sign of the true result
            sat_add = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            sat_add = s[SUM_W-1:0];
        end
    endfunction

endpackage

FILE: hw/rtl/sgs_cell.sv
`timescale 1ns / 1ps

module sgs_cell (
    input  logic           clk,
    input  sgs_pkg::ctrl_t ctrl,
    input  logic           occupied,
    input  sgs_pkg::cmp_t  left_cmp,
    input  sgs_pkg::entry_t left_ent,
    input  sgs_pkg::entry_t right_ent,
    output sgs_pkg::entry_t ent,
    output sgs_pkg::cmp_t  cmp
);
    import sgs_pkg::*;

    entry_t ent_reg;
    entry_t ent_next;

    assign ent    = ent_reg;
    assign cmp.lt = occupied && (ent_reg.key < ctrl.key);
    assign cmp.eq = occupied && (ent_reg.key == ctrl.key);

    always_comb
    begin
        ent_next = ent_reg;
        if (ctrl.drain)
        begin
            // advance towards the output end
            ent_next = right_ent;
        end
        else if (ctrl.merge && cmp.eq)
        begin
            ent_next.sum = sat_add(ent_reg.sum, ctrl.amt);
        end
        else if (ctrl.insert && !cmp.lt)
        begin
            if (left_cmp.lt)
            begin
                ent_next.key = ctrl.key;
                ent_next.sum = SUM_W'(ctrl.amt);
            end
            else
            begin
                ent_next = left_ent;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

endmodule

FILE: hw/rtl/sort_and_group_sum.sv
`timescale 1ns / 1ps

// Streaming sort and group-by-sum. A record transfers on any clock edge with
// start high and busy low, one per cycle, and is merged into a chain of
// MAX_RECORDS cells in that same cycle: a code already held adds its amount
// (saturating at the 40-bit limits), a new code is inserted at its sorted
// place with the larger entries moving one cell along, and a new code while
// the chain is full is dropped and flagged. After a record marked final the
// chain drains from its low end, one group per cycle in ascending code order,
// so busy stays high until all of the distinct codes (1 to MAX_RECORDS)
// have been put out. Each result is on the result port for one cycle with
// result_valid high; the receiver must take it then, as nothing holds it.
// end_of_groups marks the last result of the set.
module sort_and_group_sum #(
    parameter int MAX_RECORDS = sgs_pkg::MAX_RECORDS_DEF,
    parameter int KEY_BYTES   = sgs_pkg::KEY_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  sgs_pkg::rec_in_t  record,
    output sgs_pkg::rec_out_t result,
    output logic              result_valid
);
    import sgs_pkg::*;

    localparam int CNT_W = $clog2(MAX_RECORDS + 1);
    localparam logic [KEY_W-1:0] KEY_MASK =
        (KEY_BYTES >= 8) ? {KEY_W{1'b1}} : ~({KEY_W{1'b1}} >> (8 * KEY_BYTES));

    logic [CNT_W-1:0] count_reg, count_next;
    logic             drain_reg, drain_next;
    logic             overflow_reg, overflow_next;

    logic             accept;
    logic             found;
    logic             full;
    ctrl_t            ctrl;

    entry_t           ent      [MAX_RECORDS];
    cmp_t             cmp      [MAX_RECORDS];
    logic [MAX_RECORDS-1:0] eq_vec;
    logic [MAX_RECORDS-1:0] occ;

    assign busy   = drain_reg;
    assign accept = start && !drain_reg;
    assign found  = |eq_vec;
    assign full   = (count_reg == CNT_W'(MAX_RECORDS));

    assign ctrl.merge  = accept;
    assign ctrl.insert = accept && !found && !full;
    assign ctrl.drain  = drain_reg;
    assign ctrl.key    = record.product_key & KEY_MASK;
    assign ctrl.amt    = record.amount;

    genvar i;
    generate
        for (i = 0; i < MAX_RECORDS; i++)
        begin : g_cell
            cmp_t   lcmp;
            entry_t lent;
            entry_t rent;

            assign occ[i]    = CNT_W'(i) < count_reg;
            assign eq_vec[i] = cmp[i].eq;

            if (i == 0)
            begin : g_first
                // the head of the chain always takes a new code that lands here
                assign lcmp = '{lt: 1'b1, eq: 1'b0};
                assign lent = '0;
            end
            else
            begin : g_mid
                assign lcmp = cmp[i-1];
                assign lent = ent[i-1];
            end

            if (i == MAX_RECORDS - 1)
            begin : g_last
                assign rent = '0;
            end
            else
            begin : g_inner
                assign rent = ent[i+1];
            end

            sgs_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .occupied  (occ[i]),
                .left_cmp  (lcmp),
                .left_ent  (lent),
                .right_ent (rent),
                .ent       (ent[i]),
                .cmp       (cmp[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next    = count_reg;
        drain_next    = drain_reg;
        overflow_next = overflow_reg;
        if (drain_reg)
        begin
            count_next = count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1))
            begin
                drain_next    = 1'b0;
                overflow_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (ctrl.insert)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            if (!found && full)
            begin
                overflow_next = 1'b1;
            end
            if (record.final_record)
            begin
                drain_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            drain_reg    <= 1'b0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            drain_reg    <= drain_next;
            overflow_reg <= overflow_next;
        end
    end

    assign result_valid           = drain_reg;
    assign result.group_key       = ent[0].key;
    assign result.group_total     = ent[0].sum;
    assign result.end_of_groups   = drain_reg && (count_reg == CNT_W'(1));
    assign result.records_dropped = overflow_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_RECORDS))
        else $error("group count beyond chain length");

    a_final_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && record.final_record) |=> (busy && count_reg != '0))
        else $error("final record did not start a non-empty drain");

    a_drain_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.end_of_groups) |=> result_valid)
        else $error("drain stopped before the last group");

    a_drain_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.end_of_groups) |=>
            (!busy && count_reg == '0 && !result.records_dropped))
        else $error("state not cleared after the last group");

endmodule
